### hdl/lrupr_pkg.sv
// Package for the LRU page replacement block.
// Holds the fixed field widths, reset constants and the lookup status type.
// Used by lrupr_list and lru_page_replacement.
package lrupr_pkg;

  localparam int CFG_W   = 4;
  localparam int FAULT_W = 16;
  localparam int RES_W   = 4;

  localparam logic [CFG_W-1:0]   FRAME_RESET = 4'd8;
  localparam logic [FAULT_W-1:0] FAULT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic fault;
    logic evict;
  } lrupr_stat_t;

endpackage

### hdl/lru_page_replacement.sv
// LRU page replacement, top level.
// Input register, recency list lookup and update, result register.
// Depends on lrupr_pkg and lrupr_list.
//
// Each input item is one page reference; each produces exactly one result item
// with the fault flag, any evicted page, the saturating fault count and the
// number of resident pages after the reference.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. cfg_we with cfg_wdata writes the frame count, which is taken
// as 1 when zero and as MAX_FRAMES when larger; write it only while idle.
// From acceptance, the item is held in the input register and passes through
// the list logic into the result register once the result register is free.
// Throughput is one item per cycle while the receiver does not stall, set by
// the combinational parallel match and one-step shift of the recency list.
// When the receiver stalls, the result register holds its item, the input
// register still fills, and in_stall rises once both are occupied.
// Reset empties the list and both registers, clears the fault count, and sets
// the frame count to eight. The list contents are not cleared; only entries
// below the occupancy count are ever read.
module lru_page_replacement #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PAGE_BITS-1:0]          in_page_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_page_fault,
  output logic                          out_evicted_valid,
  output logic [PAGE_BITS-1:0]          out_evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0] out_fault_total,
  output logic [lrupr_pkg::RES_W-1:0]   out_resident_total
);

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);

  logic                          in_vld_r;
  logic [PAGE_BITS-1:0]          in_page_r;
  logic [lrupr_pkg::CFG_W-1:0]   frame_count_r;
  logic [lrupr_pkg::FAULT_W-1:0] fault_cnt_r;
  logic [lrupr_pkg::FAULT_W-1:0] fault_cnt_nxt;
  logic                          out_vld_r;
  logic                          fault_r;
  logic                          evict_r;
  logic [PAGE_BITS-1:0]          evict_page_r;
  logic [lrupr_pkg::FAULT_W-1:0] fault_total_r;
  logic [lrupr_pkg::RES_W-1:0]   resident_r;
  logic                          in_acc;
  logic                          proc_go;
  lrupr_pkg::lrupr_stat_t        stat;
  logic [PAGE_BITS-1:0]          victim;
  logic [OCC_W-1:0]              occ_next;

  assign proc_go  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  lrupr_list #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_list (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (proc_go),
    .page        (in_page_r),
    .frame_count (frame_count_r),
    .stat        (stat),
    .victim      (victim),
    .occ_next    (occ_next)
  );

  always_comb begin
    if (stat.fault && (fault_cnt_r != lrupr_pkg::FAULT_MAX)) begin
      fault_cnt_nxt = fault_cnt_r + lrupr_pkg::FAULT_W'(1);
    end else begin
      fault_cnt_nxt = fault_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      frame_count_r <= lrupr_pkg::FRAME_RESET;
      fault_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (proc_go) begin
        in_vld_r <= 1'b0;
      end
      if (proc_go) begin
        out_vld_r   <= 1'b1;
        fault_cnt_r <= fault_cnt_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_page_r <= in_page_number;
    end
    if (proc_go) begin
      fault_r       <= stat.fault;
      evict_r       <= stat.evict;
      evict_page_r  <= victim;
      fault_total_r <= fault_cnt_nxt;
      resident_r    <= lrupr_pkg::RES_W'(occ_next);
    end
  end

  assign out_valid          = out_vld_r;
  assign out_page_fault     = fault_r;
  assign out_evicted_valid  = evict_r;
  assign out_evicted_page   = evict_page_r;
  assign out_fault_total    = fault_total_r;
  assign out_resident_total = resident_r;

  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && evict_r |-> fault_r)
    else $error("Eviction reported without a page fault.");

  a_fault_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && stat.fault && (fault_cnt_r != lrupr_pkg::FAULT_MAX)
    |=> fault_cnt_r == $past(fault_cnt_r) + lrupr_pkg::FAULT_W'(1))
    else $error("Fault count did not advance on a page fault.");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go |-> occ_next <= OCC_W'(MAX_FRAMES))
    else $error("Occupancy exceeds the number of frames.");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(fault_total_r))
    else $error("Stalled result changed.");

endmodule

### hdl/lrupr_list.sv
// Recency list of resident pages with occupancy count, parallel match and shift.
// Computes hit, eviction and the next list in one pass; updates on upd.
// Depends on lrupr_pkg.
module lrupr_list #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic [PAGE_BITS-1:0]        page,
  input  logic [lrupr_pkg::CFG_W-1:0] frame_count,
  output lrupr_pkg::lrupr_stat_t      stat,
  output logic [PAGE_BITS-1:0]        victim,
  output logic [$clog2(MAX_FRAMES+1)-1:0] occ_next
);

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int LIM_W = (OCC_W > lrupr_pkg::CFG_W) ? OCC_W : lrupr_pkg::CFG_W;

  logic [PAGE_BITS-1:0]  rec_r   [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  rec_nxt [MAX_FRAMES];
  logic [OCC_W-1:0]      occ_r;
  logic [OCC_W-1:0]      occ_nxt;
  logic [OCC_W-1:0]      occ_dec;
  logic [OCC_W-1:0]      shift_cnt;
  logic [MAX_FRAMES-1:0] match;
  logic                  hit;
  logic [IDX_W-1:0]      hit_pos;
  logic [LIM_W-1:0]      cfg_ext;
  logic [LIM_W-1:0]      lim;
  logic                  full;

  always_comb begin
    cfg_ext = LIM_W'(frame_count);
    if (cfg_ext == '0) begin
      lim = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(MAX_FRAMES)) begin
      lim = LIM_W'(MAX_FRAMES);
    end else begin
      lim = cfg_ext;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i] = (OCC_W'(i) < occ_r) && (rec_r[i] == page);
    end
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_pos = IDX_W'(i);
      end
    end
  end

  always_comb begin
    full       = LIM_W'(occ_r) >= lim;
    occ_dec    = occ_r - OCC_W'(1);
    stat.fault = !hit;
    stat.evict = !hit && full;
    victim     = stat.evict ? rec_r[occ_dec[IDX_W-1:0]] : '0;
    if (hit) begin
      shift_cnt = OCC_W'(hit_pos);
    end else if (full) begin
      shift_cnt = occ_dec;
    end else begin
      shift_cnt = occ_r;
    end
    occ_nxt = (!hit && !full) ? occ_r + OCC_W'(1) : occ_r;
    rec_nxt[0] = page;
    for (int i = 1; i < MAX_FRAMES; i++) begin
      rec_nxt[i] = (OCC_W'(i) <= shift_cnt) ? rec_r[i-1] : rec_r[i];
    end
  end

  assign occ_next = occ_nxt;

  always_ff @(posedge clk) begin
    if (upd) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rec_r[i] <= rec_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (upd) begin
      occ_r <= occ_nxt;
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for lru_page_replacement: page references in, one result item each.
// It keeps its own LRU list, fault count and frame count, and compares every result field.
// Depends on lrupr_pkg and the lru_page_replacement RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 8;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_REFS  = 130;
  localparam int ALT_REFS    = 40;

  typedef struct packed {
    logic                          fault;
    logic                          evict;
    logic [PAGE_BITS-1:0]          victim;
    logic [lrupr_pkg::FAULT_W-1:0] faults;
    logic [lrupr_pkg::RES_W-1:0]   resident;
  } page_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [PAGE_BITS-1:0]          in_page_number = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_page_fault;
  logic                          out_evicted_valid;
  logic [PAGE_BITS-1:0]          out_evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0] out_fault_total;
  logic [lrupr_pkg::RES_W-1:0]   out_resident_total;

  lru_page_replacement #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_page_fault    (out_page_fault),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .out_resident_total(out_resident_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [PAGE_BITS-1:0]          lru_pages [MAX_FRAMES];
  logic [lrupr_pkg::RES_W-1:0]   lru_fill = '0;
  logic [lrupr_pkg::FAULT_W-1:0] fault_run = '0;
  logic [lrupr_pkg::CFG_W-1:0]   frame_reg = lrupr_pkg::FRAME_RESET;

  logic [PAGE_BITS-1:0] page_stream [$];
  page_result_t         replacement_q [$];
  int unsigned          pages_issued = 0;
  int unsigned          pages_taken = 0;
  int unsigned          fail_count = 0;
  int unsigned          cycle_count = 0;
  int                   hold_left = 0;
  logic                 page_taken = 1'b0;
  logic                 steady = 1'b0;
  logic                 hold_req = 1'b0;

  task automatic apply_reference(input logic [PAGE_BITS-1:0] page, output page_result_t r);
    int limit;
    int hit_at;
    int shift;
    limit = (frame_reg == 0) ? 1 : ((frame_reg > MAX_FRAMES) ? MAX_FRAMES : int'(frame_reg));
    hit_at = -1;
    r = '0;
    for (int i = 0; i < int'(lru_fill); i++) begin
      if (hit_at < 0 && lru_pages[i] == page) hit_at = i;
    end
    if (hit_at >= 0) begin
      shift = hit_at;
    end else begin
      r.fault = 1'b1;
      if (fault_run != lrupr_pkg::FAULT_MAX) fault_run++;
      if (int'(lru_fill) >= limit) begin
        r.evict = 1'b1;
        r.victim = lru_pages[int'(lru_fill) - 1];
        shift = int'(lru_fill) - 1;
      end else begin
        shift = int'(lru_fill);
        lru_fill++;
      end
    end
    for (int i = shift; i > 0; i--) lru_pages[i] = lru_pages[i - 1];
    lru_pages[0] = page;
    r.faults = fault_run;
    r.resident = lru_fill;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    logic                 nxt_valid;
    logic [PAGE_BITS-1:0] nxt_page;
    nxt_valid = in_valid;
    nxt_page = in_page_number;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || page_taken) begin
      nxt_valid = 1'b0;
      if (page_stream.size() > 0 && (steady || $urandom_range(0, 99) >= 9)) begin
        nxt_valid = 1'b1;
        nxt_page = page_stream.pop_front();
      end
    end
    in_valid <= nxt_valid;
    in_page_number <= nxt_page;
  end

  // The receiver stalls on its own; a requested hold-off lets the block fill up.
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && !steady && ($urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk) begin
    page_result_t want;
    page_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_we) frame_reg = cfg_wdata;
      if (page_taken) begin
        apply_reference(in_page_number, want);
        replacement_q.push_back(want);
        pages_taken++;
      end
      if (out_valid && !out_stall) begin
        if (replacement_q.size() == 0) begin
          $error("result item arrived with nothing expected");
          fail_count++;
        end else begin
          want = replacement_q.pop_front();
          check_field("page_fault", int'(want.fault), int'(out_page_fault));
          check_field("evicted_valid", int'(want.evict), int'(out_evicted_valid));
          check_field("evicted_page", int'(want.victim), int'(out_evicted_page));
          check_field("fault_total", int'(want.faults), int'(out_fault_total));
          check_field("resident_total", int'(want.resident), int'(out_resident_total));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL lru_page_replacement");
    $finish;
  end

  task automatic enqueue_page(input logic [PAGE_BITS-1:0] page);
    page_stream.push_back(page);
    pages_issued++;
  endtask

  task automatic enqueue_random(input int count, input int limit);
    logic [PAGE_BITS-1:0] base;
    int                   span;
    base = PAGE_BITS'($urandom_range(0, 255));
    span = limit + int'($urandom_range(0, 3));
    repeat (count) begin
      if ($urandom_range(0, 99) < 80) begin
        enqueue_page(PAGE_BITS'(int'(base) + int'($urandom_range(0, span - 1))));
      end else begin
        enqueue_page(PAGE_BITS'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pages_taken != pages_issued || replacement_q.size() != 0);
  endtask

  task automatic start_phase(input logic [lrupr_pkg::CFG_W-1:0] frames, input logic no_idle);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= frames;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    steady = no_idle;
  endtask

  initial begin
    logic [lrupr_pkg::CFG_W-1:0] frame_seq [7];
    int                          limit;
    frame_seq = '{4'd1, 4'd5, 4'd8, 4'd3, 4'd12, 4'd6, 4'd9};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    enqueue_page(8'd0);
    enqueue_page(8'd255);
    enqueue_page(8'd0);
    enqueue_page(8'd1);
    enqueue_page(8'd2);
    enqueue_page(8'd4);
    enqueue_page(8'd8);
    enqueue_page(8'd16);
    enqueue_page(8'd32);
    enqueue_page(8'd64);
    enqueue_page(8'd255);
    enqueue_page(8'd1);
    enqueue_page(8'd1);
    enqueue_page(8'd128);
    enqueue_page(8'hAA);
    enqueue_page(8'h55);
    enqueue_random(PHASE_REFS, 8);

    // The list stays full under a smaller frame count; each fault evicts its last page.
    start_phase(4'd2, 1'b0);
    enqueue_page(8'd3);
    enqueue_page(8'hAA);
    enqueue_page(8'd7);
    enqueue_random(PHASE_REFS, 2);
    hold_req = 1'b1;

    start_phase(4'd0, 1'b0);
    enqueue_page(8'd9);
    enqueue_page(8'd9);
    enqueue_page(8'd10);
    enqueue_random(PHASE_REFS, 1);

    start_phase(4'd15, 1'b1);
    enqueue_random(PHASE_REFS, MAX_FRAMES);

    foreach (frame_seq[k]) begin
      start_phase(frame_seq[k], 1'b0);
      limit = (frame_seq[k] > MAX_FRAMES) ? MAX_FRAMES : int'(frame_seq[k]);
      enqueue_random(PHASE_REFS, limit);
    end

    // With one frame the list stays full, so the alternating pages hit from the third on.
    start_phase(4'd1, 1'b1);
    for (int k = 0; k < ALT_REFS; k++) enqueue_page((k % 2 == 0) ? 8'h11 : 8'h22);

    start_phase(4'd8, 1'b0);
    enqueue_random(60, MAX_FRAMES);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS lru_page_replacement");
    end else begin
      $display("FAIL lru_page_replacement");
    end
    $finish;
  end

endmodule
